@@ hw/rtl/smpb_pkg.sv @@
package smpb_pkg;

  // field widths
  localparam int LEVEL_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int OUT_W     = 15;
  localparam int STEP_W    = 11;
  localparam int CFG_IDX_W = 2;

  // default window depth
  localparam int WINDOW_DEPTH_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD   = 2'd2;

  // configuration reset values, Q8.8 degrees
  localparam logic [STEP_W-1:0] ATTACK_RESET = 11'd384;
  localparam logic [STEP_W-1:0] DECAY_RESET  = 11'd256;
  localparam logic [STEP_W-1:0] DEAD_RESET   = 11'd256;

  // level curve, Q8.8 dB
  localparam logic signed [LEVEL_W-1:0] DB_MIN    = -16'sd30976;
  localparam logic signed [LEVEL_W-1:0] DB_MAX    = -16'sd3328;
  localparam logic signed [LEVEL_W-1:0] DB_KNEE   = -16'sd18688;
  localparam logic signed [LEVEL_W-1:0] DB_OFFSET = 16'sd20224;

  // slopes, Q16
  localparam int SLOPE_W = 18;
  localparam logic signed [SLOPE_W-1:0] SLOPE_LOW  = 18'sd68657;
  localparam logic signed [SLOPE_W-1:0] SLOPE_HIGH = 18'sd44447;

  // product and rounding
  localparam int PROD_W = LEVEL_W + SLOPE_W;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 34'sd32768;

  // needle limits, Q8.8 degrees
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd11264;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -16'sd11264;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LOWEST = -16'sd32768;

  // window control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } win_ctrl_t;

endpackage

@@ hw/rtl/smpb_in_if.sv @@
interface smpb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [smpb_pkg::LEVEL_W-1:0] level_db;

  modport source (output valid, output opcode, output level_db, input ready);
  modport sink   (input valid, input opcode, input level_db, output ready);
endinterface

@@ hw/rtl/smpb_out_if.sv @@
interface smpb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smpb_pkg::OUT_W-1:0] needle_angle;
  logic signed [smpb_pkg::OUT_W-1:0] window_peak;

  modport source (output valid, output needle_angle, output window_peak, input ready);
  modport sink   (input valid, input needle_angle, input window_peak, output ready);
endinterface

@@ hw/rtl/smpb_cfg_if.sv @@
interface smpb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [smpb_pkg::CFG_IDX_W-1:0]    index;
  logic [smpb_pkg::STEP_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/smpb_window.sv @@
module smpb_window #(
  parameter int DEPTH = smpb_pkg::WINDOW_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  smpb_pkg::win_ctrl_t                      ctrl,
  input  logic signed [smpb_pkg::ANGLE_W-1:0]      wr_data,
  input  logic [IDX_W-1:0]                         rd_addr,
  output logic signed [smpb_pkg::ANGLE_W-1:0]      rd_data
);

  logic signed [smpb_pkg::ANGLE_W-1:0] mem [DEPTH];
  logic signed [smpb_pkg::ANGLE_W-1:0] mem_q;
  logic [IDX_W-1:0]                    slot;
  logic [CNT_W-1:0]                    fill;
  logic                                rd_ok;

  // ring write pointer and fill count, entries past the fill read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (ctrl.wr_en) begin
      slot <= (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
      if (fill != CNT_W'(DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[slot] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      mem_q <= mem[rd_addr];
      rd_ok <= CNT_W'(rd_addr) < fill;
    end
  end

  assign rd_data = rd_ok ? mem_q : '0;

endmodule

@@ hw/rtl/signal_meter_peak_ballistics_unit.sv @@
// channel  dir  payload                          beat
// cfg      in   index[1:0], data[10:0]           valid & ready, ready always high
// item     in   opcode, level_db[15:0]           valid & ready, ready in idle step
// result   out  needle_angle[14:0], window_peak  valid & ready, held in output register
//
// a sample goes from accept to result register through its steps (clamp, multiply, round and write, emit)
// a tick runs through the start, scan, drain, move and emit steps: the single window read port walks every entry once
// rst is synchronous; the window reads as zero through its fill count, no clearing pass
// a waiting result does not block the next accept; the emit step holds until it is taken
module signal_meter_peak_ballistics_unit #(
  parameter int WINDOW_DEPTH = smpb_pkg::WINDOW_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  smpb_cfg_if.sink  cfg,
  smpb_in_if.sink   item,
  smpb_out_if.source result
);

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SEQ_W  = 4;
  localparam int ACT_W  = 4;
  localparam int COND_W = 3;
  localparam int WIDE_W = smpb_pkg::ANGLE_W + 2;

  // program steps
  localparam logic [SEQ_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [SEQ_W-1:0] STEP_SPLIT = 4'd1;
  localparam logic [SEQ_W-1:0] STEP_MUL   = 4'd2;
  localparam logic [SEQ_W-1:0] STEP_WRITE = 4'd3;
  localparam logic [SEQ_W-1:0] STEP_START = 4'd4;
  localparam logic [SEQ_W-1:0] STEP_SCAN  = 4'd5;
  localparam logic [SEQ_W-1:0] STEP_DRAIN = 4'd6;
  localparam logic [SEQ_W-1:0] STEP_MOVE  = 4'd7;
  localparam logic [SEQ_W-1:0] STEP_EMIT  = 4'd8;

  // datapath actions
  localparam logic [ACT_W-1:0] ACT_NONE   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_CLAMP  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MUL    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_START  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SCAN   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DRAIN  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_MOVE   = 4'd7;
  localparam logic [ACT_W-1:0] ACT_EMIT   = 4'd8;

  // sequencing conditions
  localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] COND_JUMP     = 3'd1;
  localparam logic [COND_W-1:0] COND_WAIT_IN  = 3'd2;
  localparam logic [COND_W-1:0] COND_IF_TICK  = 3'd3;
  localparam logic [COND_W-1:0] COND_IF_MORE  = 3'd4;
  localparam logic [COND_W-1:0] COND_WAIT_OUT = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [SEQ_W-1:0]  target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t ucode(input logic [SEQ_W-1:0] s);
    ctrl_word_t w;
    w = '{act: ACT_NONE, cond: COND_JUMP, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE:  w = '{act: ACT_NONE,  cond: COND_WAIT_IN,  target: STEP_IDLE};
      STEP_SPLIT: w = '{act: ACT_CLAMP, cond: COND_IF_TICK,  target: STEP_START};
      STEP_MUL:   w = '{act: ACT_MUL,   cond: COND_NEXT,     target: STEP_IDLE};
      STEP_WRITE: w = '{act: ACT_WRITE, cond: COND_JUMP,     target: STEP_EMIT};
      STEP_START: w = '{act: ACT_START, cond: COND_NEXT,     target: STEP_IDLE};
      STEP_SCAN:  w = '{act: ACT_SCAN,  cond: COND_IF_MORE,  target: STEP_SCAN};
      STEP_DRAIN: w = '{act: ACT_DRAIN, cond: COND_NEXT,     target: STEP_IDLE};
      STEP_MOVE:  w = '{act: ACT_MOVE,  cond: COND_NEXT,     target: STEP_IDLE};
      STEP_EMIT:  w = '{act: ACT_EMIT,  cond: COND_WAIT_OUT, target: STEP_IDLE};
      default:    w = '{act: ACT_NONE,  cond: COND_JUMP,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [SEQ_W-1:0]  step;
  logic [SEQ_W-1:0]  step_next;
  ctrl_word_t        cw;

  logic [smpb_pkg::STEP_W-1:0] attack_step;
  logic [smpb_pkg::STEP_W-1:0] decay_step;
  logic [smpb_pkg::STEP_W-1:0] dead_band;

  logic                                    tick;
  logic signed [smpb_pkg::LEVEL_W-1:0]     level;
  logic signed [smpb_pkg::LEVEL_W-1:0]     clamped;
  logic signed [smpb_pkg::LEVEL_W-1:0]     x;
  logic                                    low_seg;
  logic signed [smpb_pkg::PROD_W-1:0]      prod;
  logic signed [smpb_pkg::PROD_W-1:0]      prod_round;
  logic signed [smpb_pkg::ANGLE_W-1:0]     angle;

  logic [IDX_W-1:0]                        cnt;
  logic                                    pend;
  logic signed [smpb_pkg::ANGLE_W-1:0]     peak;
  logic signed [smpb_pkg::ANGLE_W-1:0]     rd_data;
  smpb_pkg::win_ctrl_t                     win_ctrl;

  logic signed [smpb_pkg::ANGLE_W-1:0]     needle;
  logic signed [smpb_pkg::ANGLE_W-1:0]     needle_next;
  logic signed [smpb_pkg::ANGLE_W-1:0]     last_peak;
  logic signed [WIDE_W-1:0]                n_wide;
  logic signed [WIDE_W-1:0]                p_wide;
  logic signed [WIDE_W-1:0]                band_lo;
  logic signed [WIDE_W-1:0]                band_hi;
  logic signed [WIDE_W-1:0]                moved;

  logic                                    accept;
  logic                                    out_free;
  logic                                    out_valid;
  logic signed [smpb_pkg::OUT_W-1:0]       out_needle;
  logic signed [smpb_pkg::OUT_W-1:0]       out_peak;

  assign cw       = ucode(step);
  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  // step counter with conditional jumps
  always_comb begin
    step_next = step + 1'b1;
    unique case (cw.cond)
      COND_NEXT:     step_next = step + 1'b1;
      COND_JUMP:     step_next = cw.target;
      COND_WAIT_IN:  step_next = accept ? step + 1'b1 : step;
      COND_IF_TICK:  step_next = tick ? cw.target : step + 1'b1;
      COND_IF_MORE:  step_next = (cnt != IDX_W'(WINDOW_DEPTH - 1)) ? cw.target : step + 1'b1;
      COND_WAIT_OUT: step_next = out_free ? cw.target : step;
      default:       step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign item.ready = (step == STEP_IDLE);

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step <= smpb_pkg::ATTACK_RESET;
      decay_step  <= smpb_pkg::DECAY_RESET;
      dead_band   <= smpb_pkg::DEAD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        smpb_pkg::CFG_ATTACK: attack_step <= cfg.data;
        smpb_pkg::CFG_DECAY:  decay_step  <= cfg.data;
        smpb_pkg::CFG_DEAD:   dead_band   <= cfg.data;
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      tick  <= item.opcode;
      level <= item.level_db;
    end
  end

  // level clamp and curve
  always_comb begin
    if (level < smpb_pkg::DB_MIN) begin
      clamped = smpb_pkg::DB_MIN;
    end else if (level > smpb_pkg::DB_MAX) begin
      clamped = smpb_pkg::DB_MAX;
    end else begin
      clamped = level;
    end
  end

  assign prod_round = prod + smpb_pkg::ROUND_HALF;
  assign angle      = prod_round[smpb_pkg::ANGLE_W+15:16];

  always_ff @(posedge clk) begin
    if (cw.act == ACT_CLAMP) begin
      x       <= clamped + smpb_pkg::DB_OFFSET;
      low_seg <= (clamped <= smpb_pkg::DB_KNEE);
    end
    if (cw.act == ACT_MUL) begin
      prod <= low_seg ? x * smpb_pkg::SLOPE_LOW : x * smpb_pkg::SLOPE_HIGH;
    end
  end

  // window walk, read of one entry overlaps the compare of the one before
  assign win_ctrl.wr_en = (cw.act == ACT_WRITE);
  assign win_ctrl.rd_en = (cw.act == ACT_SCAN);

  always_ff @(posedge clk) begin
    if (cw.act == ACT_START) begin
      cnt  <= '0;
      pend <= 1'b0;
      peak <= smpb_pkg::ANGLE_LOWEST;
    end else if (cw.act == ACT_SCAN || cw.act == ACT_DRAIN) begin
      cnt  <= cnt + 1'b1;
      pend <= 1'b1;
      if (pend && rd_data > peak) begin
        peak <= rd_data;
      end
    end
  end

  smpb_window #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (win_ctrl),
    .wr_data (angle),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  // needle ballistics against the window peak
  assign n_wide  = {{2{needle[smpb_pkg::ANGLE_W-1]}}, needle};
  assign p_wide  = {{2{peak[smpb_pkg::ANGLE_W-1]}}, peak};
  assign band_lo = p_wide - $signed({{(WIDE_W-smpb_pkg::STEP_W){1'b0}}, dead_band});
  assign band_hi = p_wide + $signed({{(WIDE_W-smpb_pkg::STEP_W){1'b0}}, dead_band});

  always_comb begin
    if (n_wide < band_lo) begin
      moved = n_wide + $signed({{(WIDE_W-smpb_pkg::STEP_W){1'b0}}, attack_step});
    end else if (n_wide > band_hi) begin
      moved = n_wide - $signed({{(WIDE_W-smpb_pkg::STEP_W){1'b0}}, decay_step});
    end else begin
      moved = n_wide;
    end
    if (moved < WIDE_W'(smpb_pkg::ANGLE_MIN)) begin
      needle_next = smpb_pkg::ANGLE_MIN;
    end else if (moved > WIDE_W'(smpb_pkg::ANGLE_MAX)) begin
      needle_next = smpb_pkg::ANGLE_MAX;
    end else begin
      needle_next = moved[smpb_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle    <= '0;
      last_peak <= '0;
    end else if (cw.act == ACT_MOVE) begin
      needle    <= needle_next;
      last_peak <= peak;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.act == ACT_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_EMIT && out_free) begin
      out_needle <= needle[smpb_pkg::OUT_W-1:0];
      out_peak   <= last_peak[smpb_pkg::OUT_W-1:0];
    end
  end

  assign result.valid        = out_valid;
  assign result.needle_angle = out_needle;
  assign result.window_peak  = out_peak;

endmodule
